// ----- rtl/circular_geofence_checker_defines.svh -----
// Assertion macros for the geofence checker top level.
`ifndef CIRCULAR_GEOFENCE_CHECKER_DEFINES_SVH
`define CIRCULAR_GEOFENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CGC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("geofence checker assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("geofence checker assertion failed");

`endif

// ----- rtl/cgc_pkg.sv -----
// Types and constants shared by the geofence checker modules.
`timescale 1ns / 1ps

package cgc_pkg;

   localparam int COORD_W    = 24;
   localparam int RADIUS_W   = 23;
   localparam int KIND_W     = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int MAG_W      = COORD_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int D2_W       = SQ_W + 1;
   localparam int R2_W       = 2 * RADIUS_W;

   localparam logic [KIND_W-1:0] KIND_KEEP_IN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_KEEP_OUT = 2'd2;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [RADIUS_W-1:0]       radius;
      logic [KIND_W-1:0]         kind;
   } fence_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
   } stage_type;

   typedef struct packed {
      logic valid;
      logic violation;
   } hit_type;

endpackage

// ----- rtl/cgc_fence_ram.sv -----
// Fence table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module cgc_fence_ram #(
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  cgc_pkg::fence_type wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output cgc_pkg::fence_type rd_data,
   output logic               rd_valid
);

   localparam int DATA_W = $bits(cgc_pkg::fence_type);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic              rd_valid_in;

   assign rd_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data  = cgc_pkg::fence_type'(rd_data_ff);
   assign rd_valid = rd_valid_ff;

endmodule

// ----- rtl/cgc_dist_pipe.sv -----
// Three-stage squared-distance compare of one fence against the held position.
`timescale 1ns / 1ps

module cgc_dist_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  cgc_pkg::fence_type                 fence,
   input  logic signed [cgc_pkg::COORD_W-1:0] pos_x,
   input  logic signed [cgc_pkg::COORD_W-1:0] pos_y,
   output cgc_pkg::hit_type                   hit
);

   localparam int DIFF_W = cgc_pkg::COORD_W + 1;

   // Stage A: absolute coordinate differences.
   logic signed [DIFF_W-1:0]          dx_diff;
   logic signed [DIFF_W-1:0]          dy_diff;
   logic [cgc_pkg::MAG_W-1:0]         adx_in, ady_in, adx_ff, ady_ff;
   logic [cgc_pkg::RADIUS_W-1:0]      rad_a_ff;
   cgc_pkg::stage_type                stg_a_in, stg_a_ff;

   // Stage B: squares.
   logic [cgc_pkg::SQ_W-1:0]          sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [cgc_pkg::R2_W-1:0]          r2_in, r2_ff;
   cgc_pkg::stage_type                stg_b_ff;

   // Stage C: sum and compare.
   logic [cgc_pkg::D2_W-1:0]          d2;
   logic [cgc_pkg::D2_W-1:0]          r2_wide;
   cgc_pkg::hit_type                  hit_in, hit_ff;

   always_comb begin
      dx_diff = DIFF_W'(pos_x) - DIFF_W'(fence.cx);
      dy_diff = DIFF_W'(pos_y) - DIFF_W'(fence.cy);
      adx_in  = dx_diff[DIFF_W-1] ? cgc_pkg::MAG_W'(-dx_diff) : cgc_pkg::MAG_W'(dx_diff);
      ady_in  = dy_diff[DIFF_W-1] ? cgc_pkg::MAG_W'(-dy_diff) : cgc_pkg::MAG_W'(dy_diff);
      stg_a_in.valid = in_valid;
      stg_a_in.kind  = fence.kind;
   end

   always_comb begin
      sqx_in = adx_ff * adx_ff;
      sqy_in = ady_ff * ady_ff;
      r2_in  = rad_a_ff * rad_a_ff;
   end

   always_comb begin
      d2      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      r2_wide = cgc_pkg::D2_W'(r2_ff);
      hit_in.valid     = stg_b_ff.valid;
      hit_in.violation = stg_b_ff.valid &&
         (((stg_b_ff.kind == cgc_pkg::KIND_KEEP_IN) && (d2 > r2_wide)) ||
          ((stg_b_ff.kind == cgc_pkg::KIND_KEEP_OUT) && (d2 < r2_wide)));
   end

   always_ff @(posedge clock) begin
      adx_ff   <= adx_in;
      ady_ff   <= ady_in;
      rad_a_ff <= fence.radius;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      r2_ff    <= r2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_a_ff <= '0;
         stg_b_ff <= '0;
         hit_ff   <= '0;
      end else begin
         stg_a_ff <= stg_a_in;
         stg_b_ff <= stg_a_ff;
         hit_ff   <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ----- rtl/circular_geofence_checker.sv -----
// Circular geofence checker top level: sequencer, fence table and compare pipeline.
// An add transaction gives its strobe as it leaves the add state; a check gives it as it
// leaves the scan state, once the compare results of all N stored fences are back (none if empty).
// Throughput: one transaction at a time; busy drops in the cycle the strobe shows. The check
// time is set by the single memory read port, which feeds one fence per cycle to the compare.
// Reset is synchronous: the table reads as empty, inside_ok is 1 and return_home is 0.
`timescale 1ns / 1ps
`include "circular_geofence_checker_defines.svh"

module circular_geofence_checker #(
   parameter int FENCE_SLOTS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic signed [cgc_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [cgc_pkg::COORD_W-1:0]    req_coord_y,
   input  logic [cgc_pkg::RADIUS_W-1:0]          req_radius,
   input  logic [cgc_pkg::KIND_W-1:0]            req_fence_kind,
   output logic                                  rsp_strobe,
   output logic                                  rsp_inside_ok,
   output logic                                  rsp_return_home,
   output logic [cgc_pkg::SLOT_OUT_W-1:0]        rsp_slot_index,
   output logic                                  rsp_table_full
);

   localparam int ADDR_W = (FENCE_SLOTS > 1) ? $clog2(FENCE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(FENCE_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(FENCE_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADD  = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   // Fences are never removed, so the valid slots are always 0 .. fill_cnt-1 and the
   // first free slot is simply the fill count.
   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   fill_cnt_ff, fill_cnt_in;
   logic [CNT_W-1:0]                   issue_ptr_ff, issue_ptr_in;
   logic [CNT_W-1:0]                   res_cnt_ff, res_cnt_in;
   logic                               viol_ff, viol_in;
   logic                               inside_ff, inside_in;
   logic                               home_ff, home_in;

   // Request fields held for the whole transaction.
   logic signed [cgc_pkg::COORD_W-1:0] req_x_ff, req_y_ff;
   logic [cgc_pkg::RADIUS_W-1:0]       req_rad_ff;
   logic [cgc_pkg::KIND_W-1:0]         req_kind_ff;

   // Response registers; the strobe lasts exactly one cycle.
   logic                               strobe_ff, strobe_in;
   logic [cgc_pkg::SLOT_OUT_W-1:0]     slot_ff, slot_in;
   logic                               full_ff, full_in;

   logic                               accept;
   logic                               wr_en;
   cgc_pkg::fence_type                 wr_data;
   logic                               rd_en;
   cgc_pkg::fence_type                 rd_data;
   logic                               rd_valid;
   cgc_pkg::hit_type                   hit;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Writes happen only in the add state and reads only during a scan, so the two
   // memory ports never touch the same entry in overlapping cycles.
   always_comb begin
      wr_data.cx     = req_x_ff;
      wr_data.cy     = req_y_ff;
      wr_data.radius = req_rad_ff;
      wr_data.kind   = req_kind_ff;
      wr_en = (state_ff == ST_ADD) && (fill_cnt_ff != SLOTS_CNT);
      rd_en = (state_ff == ST_SCAN) && (issue_ptr_ff < fill_cnt_ff);
   end

   always_comb begin
      state_in     = state_ff;
      fill_cnt_in  = fill_cnt_ff;
      issue_ptr_in = issue_ptr_ff;
      res_cnt_in   = res_cnt_ff;
      viol_in      = viol_ff;
      inside_in    = inside_ff;
      home_in      = home_ff;
      strobe_in    = 1'b0;
      slot_in      = slot_ff;
      full_in      = full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               issue_ptr_in = '0;
               res_cnt_in   = '0;
               viol_in      = 1'b0;
               state_in     = (req_mode == cgc_pkg::MODE_ADD) ? ST_ADD : ST_SCAN;
            end
         end
         ST_ADD: begin
            // An add reports the held flags unchanged.
            strobe_in = 1'b1;
            if (fill_cnt_ff != SLOTS_CNT) begin
               slot_in     = cgc_pkg::SLOT_OUT_W'(fill_cnt_ff);
               full_in     = 1'b0;
               fill_cnt_in = fill_cnt_ff + CNT_W'(1);
            end else begin
               slot_in = '0;
               full_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_ptr_in = issue_ptr_ff + CNT_W'(1);
            end
            if (hit.valid) begin
               res_cnt_in = res_cnt_ff + CNT_W'(1);
               viol_in    = viol_ff | hit.violation;
            end
            // All fences have come back through the pipeline: close the check.
            if (res_cnt_ff == fill_cnt_ff) begin
               inside_in = !viol_ff;
               home_in   = home_ff | viol_ff;
               slot_in   = '0;
               full_in   = 1'b0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_x_ff    <= req_coord_x;
         req_y_ff    <= req_coord_y;
         req_rad_ff  <= req_radius;
         req_kind_ff <= req_fence_kind;
      end
      slot_ff <= slot_in;
      full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_cnt_ff  <= '0;
         issue_ptr_ff <= '0;
         res_cnt_ff   <= '0;
         viol_ff      <= 1'b0;
         inside_ff    <= 1'b1;
         home_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         issue_ptr_ff <= issue_ptr_in;
         res_cnt_ff   <= res_cnt_in;
         viol_ff      <= viol_in;
         inside_ff    <= inside_in;
         home_ff      <= home_in;
         strobe_ff    <= strobe_in;
      end
   end

   cgc_fence_ram #(
      .DEPTH (FENCE_SLOTS)
   ) u_fence_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (fill_cnt_ff[ADDR_W-1:0]),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (issue_ptr_ff[ADDR_W-1:0]),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   cgc_dist_pipe u_dist_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid),
      .fence    (rd_data),
      .pos_x    (req_x_ff),
      .pos_y    (req_y_ff),
      .hit      (hit)
   );

   assign rsp_strobe      = strobe_ff;
   assign rsp_inside_ok   = inside_ff;
   assign rsp_return_home = home_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_table_full  = full_ff;

   // The table never holds more fences than it has slots.
   `CGC_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1, fill_cnt_ff <= SLOTS_CNT)
   // No compare result comes back without a read issued for it.
   `CGC_ASSERT_NOW(a_results_follow_reads, clock, reset, 1'b1, res_cnt_ff <= issue_ptr_ff)
   // A full report only happens when every slot is taken.
   `CGC_ASSERT_NOW(a_full_only_when_full, clock, reset, strobe_ff && full_ff,
                   fill_cnt_ff == SLOTS_CNT)
   // The return-home flag never falls once set.
   `CGC_ASSERT_NEXT(a_home_sticky, clock, reset, home_ff, home_ff)

endmodule

// ----- tb/sv/circular_geofence_checker_monitor.sv -----
// Monitor that predicts every geofence transaction and compares each result strobe.
`timescale 1ns / 1ps

module circular_geofence_checker_monitor #(
   parameter int FENCE_SLOTS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_mode,
   input  logic signed [cgc_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [cgc_pkg::COORD_W-1:0] req_coord_y,
   input  logic [cgc_pkg::RADIUS_W-1:0]       req_radius,
   input  logic [cgc_pkg::KIND_W-1:0]         req_fence_kind,
   input  logic                               rsp_strobe,
   input  logic                               rsp_inside_ok,
   input  logic                               rsp_return_home,
   input  logic [cgc_pkg::SLOT_OUT_W-1:0]     rsp_slot_index,
   input  logic                               rsp_table_full,
   output int                                 fail_count,
   output int                                 pending_count
);

   typedef struct {
      logic                          inside_ok;
      logic                          return_home;
      logic [cgc_pkg::SLOT_OUT_W-1:0] slot_index;
      logic                          table_full;
   } fence_verdict_type;

   // Shadow copy of the fence table and the two flags.
   logic signed [cgc_pkg::COORD_W-1:0] shadow_cx [FENCE_SLOTS];
   logic signed [cgc_pkg::COORD_W-1:0] shadow_cy [FENCE_SLOTS];
   logic [cgc_pkg::RADIUS_W-1:0]       shadow_radius [FENCE_SLOTS];
   logic [cgc_pkg::KIND_W-1:0]         shadow_kind [FENCE_SLOTS];
   logic                               shadow_used [FENCE_SLOTS];
   logic                               shadow_inside;
   logic                               shadow_home;

   fence_verdict_type verdict_queue [$];
   int                mismatch_total = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic fence_verdict_type apply_transaction(
      input logic                               mode,
      input logic signed [cgc_pkg::COORD_W-1:0] x,
      input logic signed [cgc_pkg::COORD_W-1:0] y,
      input logic [cgc_pkg::RADIUS_W-1:0]       r,
      input logic [cgc_pkg::KIND_W-1:0]         kind
   );
      fence_verdict_type v;
      int             free_slot;
      longint         dx;
      longint         dy;
      longint         dist_sq;
      longint         radius_sq;
      logic           violated;
      v.slot_index = '0;
      v.table_full = 1'b0;
      free_slot    = -1;
      if (mode == cgc_pkg::MODE_ADD) begin
         for (int i = 0; i < FENCE_SLOTS; i++) begin
            if (!shadow_used[i] && free_slot < 0) begin
               free_slot = i;
            end
         end
         if (free_slot >= 0) begin
            shadow_cx[free_slot]     = x;
            shadow_cy[free_slot]     = y;
            shadow_radius[free_slot] = r;
            shadow_kind[free_slot]   = kind;
            shadow_used[free_slot]   = 1'b1;
            v.slot_index = free_slot[cgc_pkg::SLOT_OUT_W-1:0];
         end else begin
            v.table_full = 1'b1;
         end
      end else begin
         shadow_inside = 1'b1;
         for (int i = 0; i < FENCE_SLOTS; i++) begin
            if (shadow_used[i]) begin
               dx        = longint'(x) - longint'(shadow_cx[i]);
               dy        = longint'(y) - longint'(shadow_cy[i]);
               dist_sq   = dx * dx + dy * dy;
               radius_sq = longint'(shadow_radius[i]) * longint'(shadow_radius[i]);
               violated  = (shadow_kind[i] == cgc_pkg::KIND_KEEP_IN && dist_sq > radius_sq) ||
                           (shadow_kind[i] == cgc_pkg::KIND_KEEP_OUT && dist_sq < radius_sq);
               if (violated) begin
                  shadow_inside = 1'b0;
                  shadow_home   = 1'b1;
               end
            end
         end
      end
      v.inside_ok   = shadow_inside;
      v.return_home = shadow_home;
      return v;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_total++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      fence_verdict_type want;
      if (reset) begin
         for (int i = 0; i < FENCE_SLOTS; i++) begin
            shadow_cx[i]     = '0;
            shadow_cy[i]     = '0;
            shadow_radius[i] = '0;
            shadow_kind[i]   = '0;
            shadow_used[i]   = 1'b0;
         end
         shadow_inside = 1'b1;
         shadow_home   = 1'b0;
         verdict_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (verdict_queue.size() == 0) begin
               mismatch_total++;
               $error("result strobe with no transaction outstanding");
            end else begin
               want = verdict_queue.pop_front();
               compare_field("inside_ok", int'(want.inside_ok), int'(rsp_inside_ok));
               compare_field("return_home", int'(want.return_home), int'(rsp_return_home));
               compare_field("slot_index", int'(want.slot_index), int'(rsp_slot_index));
               compare_field("table_full", int'(want.table_full), int'(rsp_table_full));
            end
         end
         if (start && !busy) begin
            verdict_queue.push_back(apply_transaction(req_mode, req_coord_x, req_coord_y,
                                                      req_radius, req_fence_kind));
         end
      end
      pending_count <= verdict_queue.size();
      fail_count    <= mismatch_total;
   end

endmodule

// ----- tb/sv/circular_geofence_checker_test.sv -----
// Top of the geofence checker testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module circular_geofence_checker_test;

   localparam int FENCE_COUNT   = 8;
   localparam int COORD_MAX     = 8388607;
   localparam int COORD_MIN     = -8388608;
   localparam int RADIUS_MAX    = 8388607;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   // Scaled 3-4-5 offsets around the small keep-out fence put a point exactly on its edge.
   localparam int HOLE_X        = 4194304;
   localparam int HOLE_Y        = 4194304;
   localparam int HOLE_RADIUS   = 1280;

   // Kinds 0 and 3 are stored like any fence but can never be violated.
   localparam logic [cgc_pkg::KIND_W-1:0] KIND_INERT_LOW  = 2'd0;
   localparam logic [cgc_pkg::KIND_W-1:0] KIND_INERT_HIGH = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_mode;
   logic signed [cgc_pkg::COORD_W-1:0] req_coord_x;
   logic signed [cgc_pkg::COORD_W-1:0] req_coord_y;
   logic [cgc_pkg::RADIUS_W-1:0]       req_radius;
   logic [cgc_pkg::KIND_W-1:0]         req_fence_kind;
   logic                               rsp_strobe;
   logic                               rsp_inside_ok;
   logic                               rsp_return_home;
   logic [cgc_pkg::SLOT_OUT_W-1:0]     rsp_slot_index;
   logic                               rsp_table_full;
   int                                 fail_count;
   int                                 pending_count;

   // Fences that were actually stored, kept so that random positions can be aimed at edges.
   int fence_x [FENCE_COUNT];
   int fence_y [FENCE_COUNT];
   int fence_r [FENCE_COUNT];
   int fence_total = 0;

   int  adds_sent    = 0;
   int  full_adds    = 0;
   int  checks_sent  = 0;
   int  cycle_count  = 0;
   bit  idle_enabled = 1'b1;

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   circular_geofence_checker #(
      .FENCE_SLOTS(FENCE_COUNT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_radius     (req_radius),
      .req_fence_kind (req_fence_kind),
      .rsp_strobe     (rsp_strobe),
      .rsp_inside_ok  (rsp_inside_ok),
      .rsp_return_home(rsp_return_home),
      .rsp_slot_index (rsp_slot_index),
      .rsp_table_full (rsp_table_full)
   );

   // The monitor sees the same pins as the block and owns all prediction and comparison.
   circular_geofence_checker_monitor #(
      .FENCE_SLOTS(FENCE_COUNT)
   ) u_monitor (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_radius     (req_radius),
      .req_fence_kind (req_fence_kind),
      .rsp_strobe     (rsp_strobe),
      .rsp_inside_ok  (rsp_inside_ok),
      .rsp_return_home(rsp_return_home),
      .rsp_slot_index (rsp_slot_index),
      .rsp_table_full (rsp_table_full),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL circular_geofence_checker");
         $finish;
      end
   end

   // Keeps a computed coordinate inside the signed 24-bit range.
   function automatic logic signed [cgc_pkg::COORD_W-1:0] clamp_coord(input int v);
      if (v > COORD_MAX) begin
         return cgc_pkg::COORD_W'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         return cgc_pkg::COORD_W'(COORD_MIN);
      end
      return cgc_pkg::COORD_W'(v);
   endfunction

   // Presents one transaction and holds it until the block takes it. Called right after a
   // rising edge, it makes exactly one assignment to start in every time step, so start is
   // never lowered and raised again within one step. When idling is on, start drops
   // with a chance of 16 in a hundred on each try, whether the block is busy or not.
   task automatic send_item(
      input logic                               mode,
      input logic signed [cgc_pkg::COORD_W-1:0] x,
      input logic signed [cgc_pkg::COORD_W-1:0] y,
      input logic [cgc_pkg::RADIUS_W-1:0]       r,
      input logic [cgc_pkg::KIND_W-1:0]         kind
   );
      bit taken;
      taken = 1'b0;
      req_mode       <= mode;
      req_coord_x    <= x;
      req_coord_y    <= y;
      req_radius     <= r;
      req_fence_kind <= kind;
      while (!taken) begin
         start <= (idle_enabled && $urandom_range(0, 99) < 16) ? 1'b0 : 1'b1;
         @(posedge clock);
         // Values read here are the ones the block saw at this edge.
         if (start && !busy) begin
            taken = 1'b1;
         end
      end
   endtask

   // An add transaction. Fences that find a free slot are remembered for aiming.
   task automatic add_fence(input int x, input int y, input int r,
                            input logic [cgc_pkg::KIND_W-1:0] kind);
      if (fence_total < FENCE_COUNT) begin
         fence_x[fence_total] = x;
         fence_y[fence_total] = y;
         fence_r[fence_total] = r;
         fence_total++;
      end else begin
         full_adds++;
      end
      adds_sent++;
      send_item(cgc_pkg::MODE_ADD, clamp_coord(x), clamp_coord(y),
                cgc_pkg::RADIUS_W'(r), kind);
   endtask

   // A check transaction. Radius and kind are ignored by the block, so they carry noise.
   task automatic check_position(input int x, input int y);
      checks_sent++;
      send_item(cgc_pkg::MODE_CHECK, clamp_coord(x), clamp_coord(y),
                cgc_pkg::RADIUS_W'($urandom_range(0, RADIUS_MAX)),
                cgc_pkg::KIND_W'($urandom_range(0, 3)));
   endtask

   // Holds start low until every outstanding result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int choice;
      int slot;
      int delta;
      int step;
      int sign_x;
      int sign_y;
      int px;
      int py;

      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = cgc_pkg::MODE_ADD;
      req_coord_x    = '0;
      req_coord_y    = '0;
      req_radius     = '0;
      req_fence_kind = KIND_INERT_LOW;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The order matters: the sticky return-home flag is only seen low
      // while the first checks are clean, so every boundary case comes before a violation.
      check_position(0, 0);                                   // no fences stored yet
      add_fence(COORD_MIN, COORD_MAX, 0, KIND_INERT_LOW);
      add_fence(COORD_MAX, COORD_MIN, RADIUS_MAX, KIND_INERT_HIGH);
      check_position(COORD_MAX, COORD_MIN);                   // inert fences never trip
      add_fence(0, 0, RADIUS_MAX, cgc_pkg::KIND_KEEP_IN);
      check_position(0, COORD_MAX);                           // exactly on the keep-in edge
      add_fence(COORD_MAX, COORD_MAX, RADIUS_MAX, cgc_pkg::KIND_KEEP_IN);
      check_position(COORD_MAX, 0);                           // on both keep-in edges
      add_fence(HOLE_X, HOLE_Y, HOLE_RADIUS, cgc_pkg::KIND_KEEP_OUT);
      check_position(HOLE_X + 768, HOLE_Y + 1024);            // exactly on the keep-out edge
      check_position(HOLE_X, HOLE_Y);                         // keep-out violation
      check_position(HOLE_X + 768, HOLE_Y + 1025);            // clean again, flag stays set
      check_position(COORD_MIN, COORD_MIN);                   // keep-in violation, far corner
      add_fence(HOLE_X, HOLE_Y + 2560, 0, cgc_pkg::KIND_KEEP_OUT);
      check_position(HOLE_X, HOLE_Y + 2560);                  // zero-radius keep-out center
      add_fence(COORD_MIN, COORD_MIN, RADIUS_MAX, cgc_pkg::KIND_KEEP_OUT);
      add_fence(2000000, 6000000, 300000, cgc_pkg::KIND_KEEP_OUT);
      add_fence(1, -1, 5, cgc_pkg::KIND_KEEP_IN);             // table is full now
      add_fence(-1, 1, RADIUS_MAX, KIND_INERT_HIGH);
      check_position(COORD_MAX, COORD_MAX);
      check_position(HOLE_X + 300000, HOLE_Y);

      // First pressure point: nothing new goes in until the directed results are back.
      wait_for_results();

      // Random part. Most transactions are checks; adds only exercise the full-table path
      // once the directed part has used every slot, but they still toggle every field bit.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_enabled = !(n >= 300 && n < 650);
         if (n == 900) begin
            wait_for_results();
         end
         choice = $urandom_range(0, 99);
         if (choice < 10) begin
            add_fence(COORD_MIN + int'($urandom_range(0, 16777215)),
                      COORD_MIN + int'($urandom_range(0, 16777215)),
                      $urandom_range(0, RADIUS_MAX),
                      cgc_pkg::KIND_W'($urandom_range(0, 3)));
         end else if (choice < 50) begin
            // Aim at the edge of a stored fence, a few LSBs either side of it.
            slot   = $urandom_range(0, fence_total - 1);
            delta  = int'($urandom_range(0, 4)) - 2;
            sign_x = $urandom_range(0, 1) ? 1 : -1;
            sign_y = $urandom_range(0, 1) ? 1 : -1;
            step   = fence_r[slot] / 5;
            case ($urandom_range(0, 2))
               0: begin
                  px = fence_x[slot] + sign_x * (fence_r[slot] + delta);
                  py = fence_y[slot];
               end
               1: begin
                  px = fence_x[slot];
                  py = fence_y[slot] + sign_y * (fence_r[slot] + delta);
               end
               default: begin
                  px = fence_x[slot] + sign_x * 3 * step;
                  py = fence_y[slot] + sign_y * (4 * step + delta);
               end
            endcase
            check_position(px, py);
         end else if (choice < 80) begin
            // Around the area shared by both large keep-in fences, where clean checks live.
            check_position(HOLE_X + int'($urandom_range(0, 2097152)) - 1048576,
                           HOLE_Y + int'($urandom_range(0, 2097152)) - 1048576);
         end else if (choice < 85) begin
            check_position($urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                           $urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
         end else begin
            check_position(COORD_MIN + int'($urandom_range(0, 16777215)),
                           COORD_MIN + int'($urandom_range(0, 16777215)));
         end
      end

      // Drain, then give a late or extra strobe time to show up.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d add transactions (%0d into a full table) and %0d position checks",
               adds_sent, full_adds, checks_sent);
      $display("against %0d stored fences, including exact edges and coordinate extremes.",
               fence_total);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS circular_geofence_checker");
      end else begin
         $display("FAIL circular_geofence_checker");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cgc_pkg.sv
rtl/cgc_fence_ram.sv
rtl/cgc_dist_pipe.sv
rtl/circular_geofence_checker.sv
tb/sv/circular_geofence_checker_monitor.sv
tb/sv/circular_geofence_checker_test.sv
